/* src/sdc_pkg.sv */
package sdc_pkg;

   localparam int MAX_ORDER  = 4096;
   localparam int DIAG_SLOTS = 2 * MAX_ORDER - 1;
   localparam int SLOT_W     = $clog2(DIAG_SLOTS);
   localparam int ORDER_W    = $clog2(MAX_ORDER + 1);

   // field widths of the stream items and the size register
   localparam int IDX_W      = 12;
   localparam int CFG_W      = 13;
   localparam int COUNT_W    = 13;
   localparam int ELEM_W     = 25;

   localparam int REQ_W      = 2 * IDX_W;
   localparam int RSP_BITS   = COUNT_W + ELEM_W;
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD    = RSP_W - RSP_BITS;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_SEL_SIZE = 1'b0;

   localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(MAX_ORDER);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MARK,
      ST_WALK,
      ST_DRAIN,
      ST_SEND
   } seq_state_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic              wr_data;
      logic [SLOT_W-1:0] rd_addr;
   } bm_req_type;

endpackage

/* src/sdc_bitmap.sv */
module sdc_bitmap (
   input  logic               clock,
   input  sdc_pkg::bm_req_type bm_req,
   output logic               rd_data
);
   import sdc_pkg::*;

   logic mem [DIAG_SLOTS];
   logic rd_data_ff;

   // read returns the old value when the same slot is written in that cycle
   always_ff @(posedge clock) begin
      if (bm_req.wr_en) begin
         mem[bm_req.wr_addr] <= bm_req.wr_data;
      end
      rd_data_ff <= mem[bm_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/sdc_csr.sv */
module sdc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sdc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sdc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sdc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready,
   output logic [sdc_pkg::ORDER_W-1:0]   order
);
   import sdc_pkg::*;

   logic [CFG_W-1:0] size_ff;
   logic [CFG_W-1:0] size_in;
   logic             wr_go;

   assign csr_pready = 1'b1;
   assign wr_go = csr_psel && csr_penable && csr_pwrite && csr_pready
                  && (csr_paddr[2] == CSR_SEL_SIZE);

   always_comb begin
      size_in = size_ff;
      if (wr_go) begin
         size_in = csr_pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_SEL_SIZE) begin
         csr_prdata = CSR_DATA_W'(size_ff);
      end
   end

   // zero acts as one, anything above the maximum as the maximum
   always_comb begin
      priority if (size_ff == '0) begin
         order = ORDER_W'(1);
      end else if (32'(size_ff) > 32'(MAX_ORDER)) begin
         order = ORDER_W'(MAX_ORDER);
      end else begin
         order = ORDER_W'(size_ff);
      end
   end

endmodule

/* src/sdc_seq.sv */
module sdc_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [sdc_pkg::ORDER_W-1:0] order,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [sdc_pkg::REQ_W-1:0]   req_tdata,
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [sdc_pkg::RSP_W-1:0]   rsp_tdata,
   output sdc_pkg::bm_req_type        bm_req,
   input  logic                      bm_rd_data
);
   import sdc_pkg::*;

   localparam int SUM_W = ((ORDER_W > IDX_W) ? ORDER_W : IDX_W) + 2;
   localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(DIAG_SLOTS - 1);
   localparam logic [SLOT_W-1:0]  SLOT_ONE  = SLOT_W'(1);
   localparam logic [ORDER_W-1:0] WT_ONE    = ORDER_W'(1);
   localparam logic [COUNT_W-1:0] CNT_ONE   = COUNT_W'(1);

   seq_state_type state_ff, state_in;

   logic [SLOT_W-1:0]  addr_ff,  addr_in;
   logic [SLOT_W-1:0]  slot_ff,  slot_in;
   logic               hit_ff,   hit_in;
   logic               last_ff,  last_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ELEM_W-1:0]  total_ff, total_in;
   logic [ORDER_W-1:0] wt_ff,    wt_in;
   logic               up_ff,    up_in;
   logic [ORDER_W-1:0] wtq_ff,   wtq_in;
   logic               pend_ff,  pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff,  rsp_data_in;

   logic [IDX_W-1:0]   row;
   logic [IDX_W-1:0]   col;
   logic [SUM_W-1:0]   row_x;
   logic [SUM_W-1:0]   col_x;
   logic [SUM_W-1:0]   ord_x;
   logic [SUM_W-1:0]   slot_sum;
   logic [SLOT_W-1:0]  slot_calc;
   logic               in_range;

   logic               accept;
   logic               sweep;
   logic               mark_set;
   logic               out_free;
   logic               send_go;

   assign row   = req_tdata[IDX_W-1:0];
   assign col   = req_tdata[2*IDX_W-1:IDX_W];
   assign row_x = SUM_W'(row);
   assign col_x = SUM_W'(col);
   assign ord_x = SUM_W'(order);

   // offset col-row biased by N-1 so slot 0 is the lowest diagonal
   assign slot_sum  = ord_x - SUM_W'(1) + col_x - row_x;
   assign slot_calc = slot_sum[SLOT_W-1:0];
   assign in_range  = (row_x < ord_x) && (col_x < ord_x);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (addr_ff == LAST_SLOT) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_MARK;
         end
         ST_MARK: begin
            state_in = last_ff ? ST_WALK : ST_IDLE;
         end
         ST_WALK: begin
            if (addr_ff == LAST_SLOT) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      accept     = req_tready && req_tvalid;
      sweep      = (state_ff == ST_CLEAR) || (state_ff == ST_WALK);
      mark_set   = (state_ff == ST_MARK) && hit_ff && !bm_rd_data;
      out_free   = !rsp_valid_ff || rsp_tready;
      send_go    = (state_ff == ST_SEND) && out_free;

      bm_req.wr_en   = 1'b0;
      bm_req.wr_addr = addr_ff;
      bm_req.wr_data = 1'b0;
      bm_req.rd_addr = addr_ff;
      unique case (state_ff)
         ST_CLEAR, ST_WALK: begin
            bm_req.wr_en = 1'b1;
         end
         ST_IDLE: begin
            bm_req.rd_addr = slot_calc;
         end
         ST_MARK: begin
            bm_req.wr_en   = mark_set;
            bm_req.wr_addr = slot_ff;
            bm_req.wr_data = 1'b1;
            bm_req.rd_addr = slot_ff;
         end
         ST_DRAIN, ST_SEND: begin
         end
         default: begin
         end
      endcase
   end

   // datapath: one adder accumulates the diagonal lengths during the sweep
   always_comb begin
      addr_in      = addr_ff;
      slot_in      = slot_ff;
      hit_in       = hit_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      wt_in        = wt_ff;
      up_in        = up_ff;
      wtq_in       = wt_ff;
      pend_in      = (state_ff == ST_WALK);
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (accept) begin
         slot_in = slot_calc;
         hit_in  = in_range;
         last_in = req_tlast;
      end

      if (mark_set) begin
         count_in = count_ff + CNT_ONE;
      end

      if ((state_ff == ST_MARK) && last_ff) begin
         addr_in  = '0;
         wt_in    = WT_ONE;
         up_in    = 1'b1;
         total_in = '0;
      end

      if (sweep) begin
         addr_in = (addr_ff == LAST_SLOT) ? '0 : addr_ff + SLOT_ONE;
      end

      // length rises 1..N up to the main diagonal, then falls to zero
      if (state_ff == ST_WALK) begin
         priority if (up_ff && (wt_ff == order)) begin
            up_in = 1'b0;
            wt_in = wt_ff - WT_ONE;
         end else if (up_ff) begin
            wt_in = wt_ff + WT_ONE;
         end else if (wt_ff != '0) begin
            wt_in = wt_ff - WT_ONE;
         end else begin
            wt_in = wt_ff;
         end
      end

      if (pend_ff && bm_rd_data) begin
         total_in = total_ff + ELEM_W'(wtq_ff);
      end

      if (send_go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {RSP_PAD'(0), total_ff, count_ff};
         count_in     = '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      hit_ff      <= hit_in;
      last_ff     <= last_in;
      total_ff    <= total_in;
      wt_ff       <= wt_in;
      up_ff       <= up_in;
      wtq_ff      <= wtq_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_walk_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && addr_ff != LAST_SLOT)
      |=> (addr_ff == $past(addr_ff) + SLOT_ONE))
      else $error("walk address skipped a slot");

   a_count_only_marks: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_MARK && state_ff != ST_SEND)
      |=> (count_ff == $past(count_ff)))
      else $error("diagonal count moved outside a mark or send");

   a_rsp_from_send: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_SEND))
      else $error("result raised outside the send step");

   a_weight_falls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && !up_ff) |=> (wt_ff <= $past(wt_ff)))
      else $error("diagonal length rose past the main diagonal");
`endif

endmodule

/* src/sparse_diagonal_counter.sv */
// Sparse diagonal counter. Each req transfer carries one nonzero (row, col) of
// a square matrix of order N set by the matrix_size register at address 0;
// entries with row or col >= N are dropped. A plain entry takes a read of the
// diagonal bitmap memory and, for a new diagonal, a write-back before the next
// is accepted. An entry with tlast set then sweeps the whole bitmap, one slot
// per cycle, reading each slot, clearing it and adding N-|d| for occupied
// diagonals in a single accumulator over all 2*MAX_ORDER-1 slots, before one
// rsp transfer carries the distinct diagonal count and element total.
// After reset the same sweep clears the bitmap with req_tready low; register
// writes are taken throughout. The result sits in an output register, so new
// entries are accepted while it waits.
module sparse_diagonal_counter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [11:0] row_index, [23:12] col_index
   input  logic [sdc_pkg::REQ_W-1:0]      req_tdata,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [12:0] diagonal_count, [37:13] diagonal_elements, [39:38] zero
   output logic [sdc_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sdc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sdc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sdc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import sdc_pkg::*;

   logic [ORDER_W-1:0] order;
   bm_req_type         bm_req;
   logic               bm_rd_data;

   sdc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .order       (order)
   );

   sdc_bitmap u_bitmap (
      .clock   (clock),
      .bm_req  (bm_req),
      .rd_data (bm_rd_data)
   );

   sdc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .order      (order),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .bm_req     (bm_req),
      .bm_rd_data (bm_rd_data)
   );

endmodule
